### rtl/rsn_pkg.sv
`timescale 1ns / 1ps
package rsn_pkg;

    localparam int MANT_BITS = 15;
    localparam int VEC_BITS  = 30;
    localparam int SQRT_W    = 64;
    localparam int ROOT_W    = SQRT_W / 2;
    localparam int QUO_W     = 17;
    localparam int DEN_W     = 33;
    localparam int NUM_W     = DEN_W + QUO_W - 1;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS   = 2'd3;

    localparam logic [16:0] ONE_Q16          = 17'd65536;
    localparam logic [16:0] HALF_Q16         = 17'd32768;
    localparam logic [15:0] SEVEN_TENTHS_Q16 = 16'd45875;
    localparam logic [15:0] MAX_Q16          = 16'hFFFF;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] radius;
    } t_cfg;

    typedef struct packed {
        logic [2:0][15:0] d;
        logic [2:0][15:0] oc;
    } t_ray;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] bmag;
        t_ray        ray;
        logic        ok;
        logic        apos;
    } t_root_side;

    typedef struct packed {
        logic [63:0] disc;
        t_root_side  side;
    } t_setup;

    typedef struct packed {
        logic [31:0] a;
        logic [15:0] dy;
        logic        ok;
        logic        apos;
    } t_carry;

    typedef struct packed {
        logic [2:0][30:0] v;
        logic [15:0]      dy;
        logic             ok;
        logic             apos;
    } t_len_side;

    typedef struct packed {
        logic ok;
        logic zero;
        logic apos;
    } t_div_side;

    function automatic logic [6:0] norm_shift(input logic [63:0] m, input int unsigned keep);
        logic [6:0] len;
        len = '0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) len = 7'(i + 1);
        end
        norm_shift = (len > 7'(keep)) ? len - 7'(keep) : '0;
    endfunction

    function automatic logic [15:0] sat16(input logic [17:0] v);
        sat16 = (v > 18'(MAX_Q16)) ? MAX_Q16 : v[15:0];
    endfunction

endpackage

### rtl/rsn_isqrt.sv
`timescale 1ns / 1ps
module rsn_isqrt
    import rsn_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQRT_W-1:0] i_x,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SW-1:0]     o_side
);

    logic [SQRT_W-1:0] st_x    [ROOT_W+1];
    logic [SQRT_W-1:0] st_r    [ROOT_W+1];
    logic              st_v    [ROOT_W+1];
    logic [SW-1:0]     st_side [ROOT_W+1];

    assign st_x[0]    = i_x;
    assign st_r[0]    = '0;
    assign st_v[0]    = i_valid;
    assign st_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
        logic [SQRT_W-1:0] trial;
        logic [SQRT_W-1:0] n_x;
        logic [SQRT_W-1:0] n_r;
        logic [SQRT_W-1:0] r_x;
        logic [SQRT_W-1:0] r_r;
        logic              r_v;
        logic [SW-1:0]     r_side;

        always_comb begin
            trial = st_r[k] + BIT;
            if (st_x[k] >= trial) begin
                n_x = st_x[k] - trial;
                n_r = (st_r[k] >> 1) + BIT;
            end else begin
                n_x = st_x[k];
                n_r = st_r[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= st_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_x;
                r_r    <= n_r;
                r_side <= st_side[k];
            end
        end

        assign st_x[k+1]    = r_x;
        assign st_r[k+1]    = r_r;
        assign st_v[k+1]    = r_v;
        assign st_side[k+1] = r_side;
    end

    assign o_valid = st_v[ROOT_W];
    assign o_root  = st_r[ROOT_W][ROOT_W-1:0];
    assign o_side  = st_side[ROOT_W];

endmodule

### rtl/rsn_div.sv
`timescale 1ns / 1ps
module rsn_div
    import rsn_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]      i_den,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [2:0][QUO_W-1:0] o_quo,
    output logic [SW-1:0]         o_side
);

    logic [2:0][NUM_W-1:0] st_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0] st_q    [QUO_W+1];
    logic [DEN_W-1:0]      st_den  [QUO_W+1];
    logic                  st_v    [QUO_W+1];
    logic [SW-1:0]         st_side [QUO_W+1];

    assign st_rem[0]  = i_num;
    assign st_q[0]    = '0;
    assign st_den[0]  = i_den;
    assign st_v[0]    = i_valid;
    assign st_side[0] = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0]      dsh;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_q;
        logic [2:0][NUM_W-1:0] r_rem;
        logic [2:0][QUO_W-1:0] r_q;
        logic [DEN_W-1:0]      r_den;
        logic                  r_v;
        logic [SW-1:0]         r_side;

        always_comb begin
            dsh = NUM_W'(st_den[k]) << SH;
            for (int l = 0; l < 3; l++) begin
                if (st_rem[k][l] >= dsh) begin
                    n_rem[l] = st_rem[k][l] - dsh;
                    n_q[l]   = {st_q[k][l][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = st_rem[k][l];
                    n_q[l]   = {st_q[k][l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= st_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_q    <= n_q;
                r_den  <= st_den[k];
                r_side <= st_side[k];
            end
        end

        assign st_rem[k+1]  = r_rem;
        assign st_q[k+1]    = r_q;
        assign st_den[k+1]  = r_den;
        assign st_v[k+1]    = r_v;
        assign st_side[k+1] = r_side;
    end

    assign o_valid = st_v[QUO_W];
    assign o_quo   = st_q[QUO_W];
    assign o_side  = st_side[QUO_W];

endmodule

### rtl/rsn_setup.sv
`timescale 1ns / 1ps
module rsn_setup
    import rsn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2:0][31:0] i_origin,
    input  logic [2:0][31:0] i_dir,
    input  t_cfg             i_cfg,
    output logic             o_valid,
    output t_setup           o_data
);

    logic [2:0][31:0] centre;
    assign centre = {i_cfg.cz, i_cfg.cy, i_cfg.cx};

    logic [7:0] r_v;

    // stage 1: offset from centre
    logic [2:0][32:0] n1_oc, r1_oc;
    logic [2:0][31:0] r1_d;
    logic [30:0]      r1_rad;

    // stage 2: magnitudes and block shifts
    logic [2:0][31:0] n2_dmag, r2_dmag;
    logic [2:0][32:0] n2_omag, r2_omag;
    logic [2:0]       r2_dneg, r2_oneg;
    logic [31:0]      n2_dor;
    logic [32:0]      n2_oor;
    logic [4:0]       n2_sd, n2_so, r2_sd, r2_so;
    logic [30:0]      r2_rad;

    // stage 3: scaled values
    t_ray             n3_ray, r3_ray;
    logic [14:0]      n3_dm, n3_om, n3_rad, r3_rad;

    // stage 4: products
    logic signed [31:0] n4_pdd [3];
    logic signed [31:0] n4_pod [3];
    logic signed [31:0] n4_poo [3];
    logic signed [31:0] r4_pdd [3];
    logic signed [31:0] r4_pod [3];
    logic signed [31:0] r4_poo [3];
    logic [29:0]        r4_prr;
    t_ray               r4_ray;

    // stage 5: quadratic coefficients
    logic [31:0]        r5_a;
    logic signed [32:0] r5_b, r5_c;
    t_ray               r5_ray;

    // stage 6: |b| and sign tests
    logic [32:0]        n6_bneg;
    logic [31:0]        r6_bmag, r6_a, r6_c;
    logic               r6_pre, r6_apos;
    t_ray               r6_ray;

    // stage 7: b^2 and a*c
    logic [63:0]        r7_b2, r7_ac;
    logic [31:0]        r7_bmag, r7_a;
    logic               r7_pre, r7_apos;
    t_ray               r7_ray;

    // stage 8: discriminant
    t_setup             r8_data;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_oc[i] = {i_origin[i][31], i_origin[i]} - {centre[i][31], centre[i]};
        end
    end

    always_comb begin
        n2_dor = '0;
        n2_oor = 33'(r1_rad);
        for (int i = 0; i < 3; i++) begin
            n2_dmag[i] = r1_d[i][31] ? -r1_d[i] : r1_d[i];
            n2_omag[i] = r1_oc[i][32] ? -r1_oc[i] : r1_oc[i];
            n2_dor     = n2_dor | n2_dmag[i];
            n2_oor     = n2_oor | n2_omag[i];
        end
        n2_sd = 5'(norm_shift(64'(n2_dor), MANT_BITS));
        n2_so = 5'(norm_shift(64'(n2_oor), MANT_BITS));
    end

    always_comb begin
        n3_dm  = '0;
        n3_om  = '0;
        n3_ray = '0;
        for (int i = 0; i < 3; i++) begin
            n3_dm         = 15'(r2_dmag[i] >> r2_sd);
            n3_om         = 15'(r2_omag[i] >> r2_so);
            n3_ray.d[i]   = r2_dneg[i] ? -{1'b0, n3_dm} : {1'b0, n3_dm};
            n3_ray.oc[i]  = r2_oneg[i] ? -{1'b0, n3_om} : {1'b0, n3_om};
        end
        n3_rad = 15'(r2_rad >> r2_so);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_pdd[i] = $signed(r3_ray.d[i]) * $signed(r3_ray.d[i]);
            n4_pod[i] = $signed(r3_ray.oc[i]) * $signed(r3_ray.d[i]);
            n4_poo[i] = $signed(r3_ray.oc[i]) * $signed(r3_ray.oc[i]);
        end
    end

    assign n6_bneg = -r5_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_oc   <= n1_oc;
            r1_d    <= i_dir;
            r1_rad  <= i_cfg.radius;

            r2_dmag <= n2_dmag;
            r2_omag <= n2_omag;
            for (int i = 0; i < 3; i++) begin
                r2_dneg[i] <= r1_d[i][31];
                r2_oneg[i] <= r1_oc[i][32];
            end
            r2_sd   <= n2_sd;
            r2_so   <= n2_so;
            r2_rad  <= r1_rad;

            r3_ray  <= n3_ray;
            r3_rad  <= n3_rad;

            r4_pdd  <= n4_pdd;
            r4_pod  <= n4_pod;
            r4_poo  <= n4_poo;
            r4_prr  <= r3_rad * r3_rad;
            r4_ray  <= r3_ray;

            r5_a    <= 32'(r4_pdd[0]) + 32'(r4_pdd[1]) + 32'(r4_pdd[2]);
            r5_b    <= r4_pod[0] + r4_pod[1] + r4_pod[2];
            r5_c    <= r4_poo[0] + r4_poo[1] + r4_poo[2] - $signed({1'b0, r4_prr});
            r5_ray  <= r4_ray;

            r6_bmag <= r5_b[32] ? n6_bneg[31:0] : r5_b[31:0];
            r6_a    <= r5_a;
            r6_c    <= r5_c[31:0];
            r6_pre  <= (r5_c > 33'sd0) && r5_b[32];
            r6_apos <= (r5_a != '0);
            r6_ray  <= r5_ray;

            r7_b2   <= r6_bmag * r6_bmag;
            r7_ac   <= r6_a * r6_c;
            r7_bmag <= r6_bmag;
            r7_a    <= r6_a;
            r7_pre  <= r6_pre;
            r7_apos <= r6_apos;
            r7_ray  <= r6_ray;

            r8_data.side.ok   <= r7_pre && (r7_b2 >= r7_ac);
            r8_data.disc      <= (r7_pre && (r7_b2 >= r7_ac)) ? r7_b2 - r7_ac : '0;
            r8_data.side.a    <= r7_a;
            r8_data.side.bmag <= r7_bmag;
            r8_data.side.ray  <= r7_ray;
            r8_data.side.apos <= r7_apos;
        end
    end

    assign o_valid = r_v[7];
    assign o_data  = r8_data;

endmodule

### rtl/ray_sphere_normal_shade.sv
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// ray in    input      i_valid / o_stall   i_origin_x/y/z, i_dir_x/y/z
// colour    output     o_valid / i_stall   o_hit, o_red, o_green, o_blue
// config    input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// one ray per cycle while o_stall is low; 99 register stages lie between the ray input and the colour outputs
// most of those stages lie in the two 32-stage square root pipes and the 17-stage divider
// synchronous active-low reset clears the valid bits and loads the default sphere
// while a result waits under i_stall the whole pipe holds and o_stall is raised
module ray_sphere_normal_shade
    import rsn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [31:0] CZ_RST  = 32'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [30:0] RAD_RST = 31'(1) << (FRAC_BITS - 1);

    t_cfg r_cfg;
    logic en;
    logic r_out_v;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cx     <= '0;
            r_cfg.cy     <= '0;
            r_cfg.cz     <= CZ_RST;
            r_cfg.radius <= RAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_cfg.cx     <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.cy     <= i_cfg_data;
                CFG_CENTER_Z: r_cfg.cz     <= i_cfg_data;
                CFG_RADIUS:   r_cfg.radius <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // coefficients and discriminant
    logic   su_v;
    t_setup su_data;

    rsn_setup u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_origin ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir    ({i_dir_z, i_dir_y, i_dir_x}),
        .i_cfg    (r_cfg),
        .o_valid  (su_v),
        .o_data   (su_data)
    );

    logic        s1_v;
    logic [31:0] s1_root;
    t_root_side  s1_side;

    rsn_isqrt #(.SW($bits(t_root_side))) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (su_v),
        .i_x     (su_data.disc),
        .i_side  (su_data.side),
        .o_valid (s1_v),
        .o_root  (s1_root),
        .o_side  (s1_side)
    );

    // normal vector
    logic [6:0]  r_nv;
    logic [31:0] r_n1_m;
    t_root_side  r_n1_side;

    logic signed [48:0] n_pa [3];
    logic signed [48:0] n_pm [3];
    logic signed [48:0] r_n2_pa [3];
    logic signed [48:0] r_n2_pm [3];
    t_carry             r_n2_c;

    logic signed [49:0] r_n3_v [3];
    t_carry             r_n3_c;

    logic [2:0][49:0]   n_mag, r_n4_mag;
    logic [49:0]        n_vor;
    logic [2:0]         r_n4_neg;
    logic [4:0]         r_n4_sv;
    t_carry             r_n4_c;

    logic [2:0][29:0]   n_vm, r_n5_vm;
    logic [2:0][30:0]   n_vs, r_n5_v;
    t_carry             r_n5_c;

    logic [2:0][59:0]   r_n6_sq;
    logic [2:0][30:0]   r_n6_v;
    t_carry             r_n6_c;

    logic [61:0]        r_n7_sq;
    logic [2:0][30:0]   r_n7_v;
    t_carry             r_n7_c;

    t_len_side          n7_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = $signed({1'b0, r_n1_side.a}) * $signed(r_n1_side.ray.oc[i]);
            n_pm[i] = $signed({1'b0, r_n1_m}) * $signed(r_n1_side.ray.d[i]);
        end
    end

    always_comb begin
        n_vor = '0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_n3_v[i][49] ? -r_n3_v[i] : r_n3_v[i];
            n_vor    = n_vor | n_mag[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vm[i] = 30'(r_n4_mag[i] >> r_n4_sv);
            n_vs[i] = r_n4_neg[i] ? -{1'b0, n_vm[i]} : {1'b0, n_vm[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= '0;
        end else if (en) begin
            r_nv <= {r_nv[5:0], s1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n1_m    <= s1_side.bmag - s1_root;
            r_n1_side <= s1_side;

            r_n2_pa     <= n_pa;
            r_n2_pm     <= n_pm;
            r_n2_c.a    <= r_n1_side.a;
            r_n2_c.dy   <= r_n1_side.ray.d[1];
            r_n2_c.ok   <= r_n1_side.ok;
            r_n2_c.apos <= r_n1_side.apos;

            for (int i = 0; i < 3; i++) begin
                r_n3_v[i] <= r_n2_pa[i] + r_n2_pm[i];
                r_n4_neg[i] <= r_n3_v[i][49];
            end
            r_n3_c   <= r_n2_c;

            r_n4_mag <= n_mag;
            r_n4_sv  <= 5'(norm_shift(64'(n_vor), VEC_BITS));
            r_n4_c   <= r_n3_c;

            r_n5_vm  <= n_vm;
            r_n5_v   <= n_vs;
            r_n5_c   <= r_n4_c;

            for (int i = 0; i < 3; i++) begin
                r_n6_sq[i] <= r_n5_vm[i] * r_n5_vm[i];
            end
            r_n6_v   <= r_n5_v;
            r_n6_c   <= r_n5_c;

            r_n7_sq  <= 62'(r_n6_sq[0]) + 62'(r_n6_sq[1]) + 62'(r_n6_sq[2]);
            r_n7_v   <= r_n6_v;
            r_n7_c   <= r_n6_c;
        end
    end

    assign n7_side.v    = r_n7_v;
    assign n7_side.dy   = r_n7_c.dy;
    assign n7_side.ok   = r_n7_c.ok;
    assign n7_side.apos = r_n7_c.apos;

    // length of the normal on a hit, length of the direction on a miss
    logic        s2_v;
    logic [31:0] s2_root;
    t_len_side   s2_side;

    rsn_isqrt #(.SW($bits(t_len_side))) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nv[6]),
        .i_x     (r_n7_c.ok ? 64'(r_n7_sq) : 64'(r_n7_c.a)),
        .i_side  (n7_side),
        .o_valid (s2_v),
        .o_root  (s2_root),
        .o_side  (s2_side)
    );

    // divider operands
    logic                  r_d1_v;
    logic [2:0][NUM_W-1:0] n_num, r_d1_num;
    logic [DEN_W-1:0]      r_d1_den;
    t_div_side             r_d1_side;
    logic [30:0]           n_vsel [3];
    logic signed [33:0]    n_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i == 1 && !s2_side.ok) begin
                n_vsel[i] = {{15{s2_side.dy[15]}}, s2_side.dy};
            end else begin
                n_vsel[i] = s2_side.v[i];
            end
            n_sum[i] = $signed({{3{n_vsel[i][30]}}, n_vsel[i]}) + $signed({2'b00, s2_root});
            n_num[i] = {n_sum[i][DEN_W-1:0], {(QUO_W-1){1'b0}}} + NUM_W'(s2_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
        end else if (en) begin
            r_d1_v <= s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_num       <= n_num;
            r_d1_den       <= {s2_root, 1'b0};
            r_d1_side.ok   <= s2_side.ok;
            r_d1_side.zero <= (s2_root == '0);
            r_d1_side.apos <= s2_side.apos;
        end
    end

    logic                  dv_v;
    logic [2:0][QUO_W-1:0] dv_q;
    t_div_side             dv_side;

    rsn_div #(.SW($bits(t_div_side))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d1_v),
        .i_num   (r_d1_num),
        .i_den   (r_d1_den),
        .i_side  (r_d1_side),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_side  (dv_side)
    );

    // colour
    logic             r_p1_v;
    logic [2:0][15:0] r_p1_col;
    logic [16:0]      n_u, r_p1_u;
    logic [32:0]      r_p1_gm;
    logic             r_p1_ok;

    logic             r_hit;
    logic [15:0]      r_red, r_green, r_blue;
    logic [32:0]      n_gm_rnd;
    logic [17:0]      n_red_sky, n_green_sky;

    assign n_u = dv_side.apos ? dv_q[1] : HALF_Q16;

    always_comb begin
        n_gm_rnd    = r_p1_gm + 33'(HALF_Q16);
        n_red_sky   = 18'(ONE_Q16) - 18'(r_p1_u) + 18'((r_p1_u + 17'd1) >> 1);
        n_green_sky = 18'(ONE_Q16) - 18'(r_p1_u) + 18'(n_gm_rnd >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_p1_v  <= dv_v;
            r_out_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_col[i] <= dv_side.zero ? HALF_Q16[15:0] : sat16(18'(dv_q[i]));
            end
            r_p1_u  <= n_u;
            r_p1_gm <= n_u * SEVEN_TENTHS_Q16;
            r_p1_ok <= dv_side.ok;

            r_hit <= r_p1_ok;
            if (r_p1_ok) begin
                r_red   <= r_p1_col[0];
                r_green <= r_p1_col[1];
                r_blue  <= r_p1_col[2];
            end else begin
                r_red   <= sat16(n_red_sky);
                r_green <= sat16(n_green_sky);
                r_blue  <= MAX_Q16;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_hit   = r_hit;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### tb/tb_ray_sphere_normal_shade.sv
`timescale 1ns / 1ps
module tb_ray_sphere_normal_shade;
    import rsn_pkg::*;

    typedef struct {
        int ox, oy, oz;
        int dx, dy, dz;
    } t_ray_in;

    typedef struct {
        bit        hit;
        bit [15:0] red;
        bit [15:0] green;
        bit [15:0] blue;
    } t_colour;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic        o_valid;
    logic        i_stall;
    logic        o_hit;
    logic [15:0] o_red, o_green, o_blue;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    ray_sphere_normal_shade u_top (.*);

    t_ray_in pending_rays[$];
    t_colour expected_colours[$];
    int      sph_cx, sph_cy, sph_cz;
    int      sph_r;
    int      fails;
    bit      quiet;
    bit      hold_req;
    int      send_gap;
    int      recv_gap;
    int      hold_left;
    int      idle_cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic int scale_bits(longint unsigned m, int bits);
        int s;
        s = 0;
        while ((m >> s) >= (64'd1 << bits)) s++;
        return s;
    endfunction

    function automatic longint shift_keep_sign(longint v, int s);
        longint unsigned m;
        m = mag64(v) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [15:0] clip16(longint unsigned v);
        return v > 65535 ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit [15:0] sky_mix(longint unsigned u, longint unsigned k);
        return clip16(65536 - u + ((u * k + 32768) >> 16));
    endfunction

    function automatic t_colour shade_ray(t_ray_in ry);
        t_colour         c;
        longint          oc[3], dd[3], v[3];
        longint          rr, a, b, cc, m;
        longint unsigned md, mo, mv, b2, ac, sq, len, u, la;
        int              sd, so, sv;
        oc[0] = longint'(ry.ox) - longint'(sph_cx);
        oc[1] = longint'(ry.oy) - longint'(sph_cy);
        oc[2] = longint'(ry.oz) - longint'(sph_cz);
        dd[0] = ry.dx;
        dd[1] = ry.dy;
        dd[2] = ry.dz;
        md = 0;
        mo = longint'(sph_r);
        mv = 0;
        for (int i = 0; i < 3; i++) begin
            if (mag64(dd[i]) > md) md = mag64(dd[i]);
            if (mag64(oc[i]) > mo) mo = mag64(oc[i]);
        end
        sd = scale_bits(md, MANT_BITS);
        so = scale_bits(mo, MANT_BITS);
        rr = shift_keep_sign(longint'(sph_r), so);
        a = 0;
        b = 0;
        cc = 0;
        for (int i = 0; i < 3; i++) begin
            dd[i] = shift_keep_sign(dd[i], sd);
            oc[i] = shift_keep_sign(oc[i], so);
            a += dd[i] * dd[i];
            b += oc[i] * dd[i];
            cc += oc[i] * oc[i];
        end
        cc -= rr * rr;
        if (cc > 0 && b < 0) begin
            b2 = mag64(b) * mag64(b);
            ac = longint'(a) * longint'(cc);
            if (b2 >= ac) begin
                m = longint'(mag64(b) - root64(b2 - ac));
                for (int i = 0; i < 3; i++) begin
                    v[i] = a * oc[i] + m * dd[i];
                    if (mag64(v[i]) > mv) mv = mag64(v[i]);
                end
                sv = scale_bits(mv, VEC_BITS);
                sq = 0;
                for (int i = 0; i < 3; i++) begin
                    v[i] = shift_keep_sign(v[i], sv);
                    sq += mag64(v[i]) * mag64(v[i]);
                end
                len = root64(sq);
                c.hit = 1'b1;
                if (len == 0) begin
                    c.red = 16'd32768;
                    c.green = 16'd32768;
                    c.blue = 16'd32768;
                end else begin
                    c.red = clip16((longint'(v[0] + longint'(len)) * 65536 + len) / (2 * len));
                    c.green = clip16((longint'(v[1] + longint'(len)) * 65536 + len) / (2 * len));
                    c.blue = clip16((longint'(v[2] + longint'(len)) * 65536 + len) / (2 * len));
                end
                return c;
            end
        end
        u = 32768;
        if (a > 0) begin
            la = root64(a);
            u = (longint'(dd[1] + longint'(la)) * 65536 + la) / (2 * la);
        end
        c.hit = 1'b0;
        c.red = sky_mix(u, 32768);
        c.green = sky_mix(u, 45875);
        c.blue = sky_mix(u, 65536);
        return c;
    endfunction

    function automatic int signed_rand(int bits);
        longint r;
        r = longint'($urandom) & ((64'd1 << bits) - 1);
        return $urandom_range(0, 1) ? int'(r) : -int'(r);
    endfunction

    function automatic t_ray_in make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray_in ry;
        ry.ox = ox; ry.oy = oy; ry.oz = oz;
        ry.dx = dx; ry.dy = dy; ry.dz = dz;
        return ry;
    endfunction

    function automatic t_ray_in random_ray();
        t_ray_in ry;
        int      off[3];
        int      spread, noise;
        if ($urandom_range(0, 9) < 3) begin
            ry.ox = $urandom; ry.oy = $urandom; ry.oz = $urandom;
            ry.dx = $urandom; ry.dy = $urandom; ry.dz = $urandom;
            if ($urandom_range(0, 3) == 0) ry.dx = signed_rand($urandom_range(0, 20));
            return ry;
        end
        // aimed near the sphere so that hits, grazes and near misses dominate
        spread = $urandom_range(4, 26);
        noise = $urandom_range(0, spread);
        for (int i = 0; i < 3; i++) off[i] = signed_rand(spread);
        ry.ox = sph_cx + off[0];
        ry.oy = sph_cy + off[1];
        ry.oz = sph_cz + off[2];
        ry.dx = -off[0] + signed_rand(noise);
        ry.dy = -off[1] + signed_rand(noise);
        ry.dz = -off[2] + signed_rand(noise);
        if ($urandom_range(0, 4) == 0) begin
            ry.dx = -ry.dx; ry.dy = -ry.dy; ry.dz = -ry.dz;
        end
        return ry;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CENTER_X: sph_cx = data;
            CFG_CENTER_Y: sph_cy = data;
            CFG_CENTER_Z: sph_cz = data;
            CFG_RADIUS:   sph_r = {1'b0, data[30:0]};
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(int cx, int cy, int cz, logic [31:0] r);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, r);
    endtask

    task automatic add_random(int n);
        repeat (n) pending_rays.push_back(random_ray());
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_rays.size() != 0 || i_valid || expected_colours.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ray driver
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) expected_colours.push_back(shade_ray(make_ray(
                int'(i_origin_x), int'(i_origin_y), int'(i_origin_z),
                int'(i_dir_x), int'(i_dir_y), int'(i_dir_z))));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_rays.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 12);
                i_valid <= 1'b0;
            end else if (pending_rays.size() != 0) begin
                t_ray_in ry;
                ry = pending_rays.pop_front();
                i_origin_x <= ry.ox;
                i_origin_y <= ry.oy;
                i_origin_z <= ry.oz;
                i_dir_x <= ry.dx;
                i_dir_y <= ry.dy;
                i_dir_z <= ry.dz;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // colour monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_colours.size() == 0) begin
                    $error("colour transfer with nothing expected");
                    fails++;
                end else begin
                    t_colour e;
                    e = expected_colours.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit: expected %0d actual %0d", e.hit, o_hit);
                        fails++;
                    end
                    if (o_red !== e.red) begin
                        $error("red: expected %0d actual %0d", e.red, o_red);
                        fails++;
                    end
                    if (o_green !== e.green) begin
                        $error("green: expected %0d actual %0d", e.green, o_green);
                        fails++;
                    end
                    if (o_blue !== e.blue) begin
                        $error("blue: expected %0d actual %0d", e.blue, o_blue);
                        fails++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req <= 1'b0;
                hold_left <= 400;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (pending_rays.size() == 0 && !i_valid && expected_colours.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CENTER_X;
        i_cfg_data = '0;
        fails = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        idle_cycles = 0;
        sph_cx = 0;
        sph_cy = 0;
        sph_cz = -65536;
        sph_r = 32768;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default sphere after reset
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, -65536));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 65536));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 65536, 0));
        pending_rays.push_back(make_ray(0, 0, 0, 0, -65536, 0));
        pending_rays.push_back(make_ray(0, 0, -65536, 0, 0, -65536));
        pending_rays.push_back(make_ray(0, 0, -32768, 65536, 0, 0));
        pending_rays.push_back(make_ray(0, 32768, 0, 0, 0, -65536));
        pending_rays.push_back(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_rays.push_back(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                        32'h80000000, 32'h80000000, 32'h80000000));
        pending_rays.push_back(make_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                        32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        pending_rays.push_back(make_ray(0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 32'h80000000, 0));
        pending_rays.push_back(make_ray(0, 0, 0, 1, 0, -1));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 1, 0));
        add_random(600);
        hold_req = 1'b1;
        drain();

        // centre and radius at their extremes, bit above the radius width set
        set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        pending_rays.push_back(make_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        pending_rays.push_back(make_ray(0, 0, 0, 32'h7FFFFFFF, 0, 0));
        add_random(300);
        drain();

        // zero radius, ray aimed straight at the centre gives a degenerate normal
        set_sphere(65536, 0, -131072, 0);
        pending_rays.push_back(make_ray(0, 0, 0, 65536, 0, -131072));
        pending_rays.push_back(make_ray(0, 0, 0, 32768, 0, -65536));
        pending_rays.push_back(make_ray(65536, 0, -131072, 65536, 0, 0));
        add_random(200);
        drain();

        set_sphere(signed_rand(22), signed_rand(22), signed_rand(22), $urandom_range(1, 1 << 22));
        add_random(600);
        wait (pending_rays.size() < 200);
        quiet = 1'b1;
        drain();

        repeat (120) @(posedge i_clk);
        if (fails == 0 && expected_colours.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
